// ===== sv/scbpa_pkg.sv =====
// Shared types, codes and constants for the size-class buffer pool accounting block.
`default_nettype none

package scbpa_pkg;

  localparam int NUM_CLASSES_DEF     = 5;
  localparam int MIN_SIZE_LOG2_DEF   = 12;
  localparam int INITIAL_ENTRIES_DEF = 10;
  localparam int BUDGET_RESET        = 20;
  localparam int QUEUE_DEPTH         = 2;
  localparam int COUNT_W             = 16;
  localparam int CLASS_W             = 3;
  localparam int BUDGET_W            = 5;

  // Request kinds after classification.
  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_PUT     = 2'd1;
  localparam logic [1:0] OP_OVR_GET = 2'd2;
  localparam logic [1:0] OP_OVR_PUT = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_REUSED        = 3'd0;
  localparam logic [2:0] ACT_CREATED       = 3'd1;
  localparam logic [2:0] ACT_OVR_CREATED   = 3'd2;
  localparam logic [2:0] ACT_POOLED        = 3'd3;
  localparam logic [2:0] ACT_DESTROYED     = 3'd4;
  localparam logic [2:0] ACT_OVR_DESTROYED = 3'd5;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] req_size;
    logic [2:0]  return_class;
  } req_t;

  typedef struct packed {
    logic [2:0]  class_index;
    logic [2:0]  action;
    logic [15:0] free_after;
    logic [15:0] total_after;
    logic        count_saturated;
  } resp_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]         op;
    logic [CLASS_W-1:0] cls;
  } cmd_t;

  // Count held by a class after reset: the initial entries, limited by the
  // class cap at the reset budget and by the counter range.
  function automatic logic [COUNT_W-1:0] reset_count(input int initial_entries,
                                                     input int min_log2,
                                                     input int cls);
    int lg;
    int cap;
    int n;
    lg  = min_log2 + cls;
    cap = (BUDGET_RESET <= lg) ? 1 : (1 << (BUDGET_RESET - lg));
    n   = (initial_entries > cap) ? cap : initial_entries;
    n   = (n > 65535) ? 65535 : n;
    return COUNT_W'(n);
  endfunction

endpackage

`default_nettype wire

// ===== sv/scbpa_front.sv =====
// Front end: accepts request items and maps them to a class and a command.
`default_nettype none

module scbpa_front #(
  parameter int NUM_CLASSES   = 5,
  parameter int MIN_SIZE_LOG2 = 12
) (
  input  wire logic           in_valid,
  input  wire scbpa_pkg::req_t in_item,
  output logic                in_ready,
  input  wire logic           q_ready,
  output logic                push,
  output scbpa_pkg::cmd_t     cmd
);
  import scbpa_pkg::*;

  localparam logic [CLASS_W-1:0] OVR_CODE =
    (NUM_CLASSES > 7) ? CLASS_W'(7) : CLASS_W'(NUM_CLASSES);

  logic [CLASS_W-1:0] get_cls;
  logic               put_ovr;

  // Smallest class whose buffer size covers the request; the classes are
  // nested, so scanning downwards leaves the smallest match.
  always_comb begin
    get_cls = OVR_CODE;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({1'b0, in_item.req_size} <= (33'd1 << (MIN_SIZE_LOG2 + i))) begin
        get_cls = CLASS_W'(i);
      end
    end
  end

  assign put_ovr = ({1'b0, in_item.return_class} >= 4'(NUM_CLASSES));

  always_comb begin
    if (in_item.req_type == REQ_GET) begin
      cmd.cls = get_cls;
      cmd.op  = (get_cls == OVR_CODE) ? OP_OVR_GET : OP_GET;
    end else begin
      cmd.cls = put_ovr ? OVR_CODE : in_item.return_class;
      cmd.op  = put_ovr ? OP_OVR_PUT : OP_PUT;
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

endmodule

`default_nettype wire

// ===== sv/scbpa_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module scbpa_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire scbpa_pkg::cmd_t push_cmd,
  output logic                 ready,
  input  wire logic            pop,
  output logic                 valid,
  output scbpa_pkg::cmd_t      head
);
  import scbpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready = (count != CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/scbpa_back.sv =====
// Back end: per-class counters, cap check and the registered result.
`default_nettype none

module scbpa_back #(
  parameter int NUM_CLASSES     = 5,
  parameter int MIN_SIZE_LOG2   = 12,
  parameter int INITIAL_ENTRIES = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [scbpa_pkg::BUDGET_W-1:0]    budget_log2,
  input  wire logic                              q_valid,
  input  wire scbpa_pkg::cmd_t                   q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output scbpa_pkg::resp_t                       out_item
);
  import scbpa_pkg::*;

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [COUNT_W-1:0] free_count  [NUM_CLASSES];
  logic [COUNT_W-1:0] total_count [NUM_CLASSES];

  logic [IDX_W-1:0]   idx;
  logic [COUNT_W-1:0] fc;
  logic [COUNT_W-1:0] tc;
  logic [COUNT_W-1:0] free_next;
  logic [COUNT_W-1:0] total_next;
  logic [5:0]         lg;
  logic [5:0]         expo;
  logic               over_cap;
  logic               count_wr;
  resp_t              rsp_next;

  assign idx = q_head.cls[IDX_W-1:0];
  assign fc  = free_count[idx];
  assign tc  = total_count[idx];

  // The cap is 2^(budget - class log2 size), or one when the budget is at
  // or below the class size; a cap of 2^16 or more is never exceeded.
  assign lg   = 6'(MIN_SIZE_LOG2) + {3'b000, q_head.cls};
  assign expo = {1'b0, budget_log2} - lg;

  always_comb begin
    if ({1'b0, budget_log2} <= lg) begin
      over_cap = (tc > COUNT_W'(1));
    end else if (expo >= 6'd16) begin
      over_cap = 1'b0;
    end else begin
      over_cap = ({1'b0, tc} > (17'd1 << expo[3:0]));
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    free_next  = fc;
    total_next = tc;
    count_wr   = 1'b0;
    rsp_next   = '0;
    rsp_next.class_index = q_head.cls;
    unique case (q_head.op)
      OP_GET: begin
        count_wr = 1'b1;
        if (fc != '0) begin
          free_next       = fc - 1'b1;
          rsp_next.action = ACT_REUSED;
        end else begin
          rsp_next.action = ACT_CREATED;
          if (tc == '1) begin
            rsp_next.count_saturated = 1'b1;
          end else begin
            total_next = tc + 1'b1;
          end
        end
        rsp_next.free_after  = free_next;
        rsp_next.total_after = total_next;
      end
      OP_PUT: begin
        count_wr = 1'b1;
        if (over_cap) begin
          total_next      = tc - 1'b1;
          rsp_next.action = ACT_DESTROYED;
        end else begin
          rsp_next.action = ACT_POOLED;
          if (fc == '1) begin
            rsp_next.count_saturated = 1'b1;
          end else begin
            free_next = fc + 1'b1;
          end
        end
        rsp_next.free_after  = free_next;
        rsp_next.total_after = total_next;
      end
      OP_OVR_GET: begin
        rsp_next.action = ACT_OVR_CREATED;
      end
      OP_OVR_PUT: begin
        rsp_next.action = ACT_OVR_DESTROYED;
      end
      default: begin
        rsp_next.action = ACT_OVR_DESTROYED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        free_count[i]  <= reset_count(INITIAL_ENTRIES, MIN_SIZE_LOG2, i);
        total_count[i] <= reset_count(INITIAL_ENTRIES, MIN_SIZE_LOG2, i);
      end
    end else if (q_pop && count_wr) begin
      free_count[idx]  <= free_next;
      total_count[idx] <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/size_class_buffer_pool_accounting.sv =====
// Top level of the size-class buffer pool accounting block.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_item   (req_t)
//   out       output     out_valid / out_ready out_item  (resp_t)
//   cfg       input      cfg_wr_en             cfg_wr_data (budget_log2)
//
// One item is taken every cycle when nothing stalls. An accepted item is
// classified at once and written to a two-entry command queue; the back end
// pops it from the queue, updates the class counters in a single
// read-modify-write and registers the result, which is presented from the
// output register until it is taken. Because that read-modify-write reads
// and writes the counters at the same pop, consecutive items on the same
// class see each other's updates.
// Reset is synchronous and loads every class counter with its initial count
// in the same cycle, so there is no clearing pass. When the output stalls,
// the output register holds and the queue fills; in_ready falls once the
// queue is full.
`default_nettype none

module size_class_buffer_pool_accounting #(
  parameter int NUM_CLASSES     = scbpa_pkg::NUM_CLASSES_DEF,
  parameter int MIN_SIZE_LOG2   = scbpa_pkg::MIN_SIZE_LOG2_DEF,
  parameter int INITIAL_ENTRIES = scbpa_pkg::INITIAL_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire scbpa_pkg::req_t                in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output scbpa_pkg::resp_t                    out_item,
  input  wire logic                           cfg_wr_en,
  input  wire logic [scbpa_pkg::BUDGET_W-1:0] cfg_wr_data
);
  import scbpa_pkg::*;

  // The budget register sets the per-class caps; it only affects puts that reach the back end after it is written.
  logic [BUDGET_W-1:0] budget_log2;

  logic q_ready;
  logic q_push;
  logic q_valid;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_log2 <= BUDGET_W'(BUDGET_RESET);
    end else if (cfg_wr_en) begin
      budget_log2 <= cfg_wr_data;
    end
  end

  // Front end: class lookup for gets, range check for puts.
  scbpa_front #(
    .NUM_CLASSES   (NUM_CLASSES),
    .MIN_SIZE_LOG2 (MIN_SIZE_LOG2)
  ) u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .q_ready  (q_ready),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  // Decouples acceptance from the counter update and the output stall.
  scbpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: counters, cap check and the result register.
  scbpa_back #(
    .NUM_CLASSES     (NUM_CLASSES),
    .MIN_SIZE_LOG2   (MIN_SIZE_LOG2),
    .INITIAL_ENTRIES (INITIAL_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .budget_log2 (budget_log2),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

// ===== sv/scbpa_checker.sv =====
// Port-level checks for the size-class buffer pool accounting block.
`default_nettype none

module scbpa_checker #(
  parameter int NUM_CLASSES = 5
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire scbpa_pkg::resp_t out_item
);
  import scbpa_pkg::*;

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented straight after reset");

  // Oversized results carry no counts.
  a_ovr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.action == ACT_OVR_CREATED ||
                  out_item.action == ACT_OVR_DESTROYED)
    |-> out_item.free_after == '0 && out_item.total_after == '0 &&
        !out_item.count_saturated)
    else $error("oversized result with non-zero counts");

  // Saturation is only flagged on a create or pool that hit the count limit.
  a_sat_only_at_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.count_saturated
    |-> (out_item.action == ACT_CREATED && out_item.total_after == '1) ||
        (out_item.action == ACT_POOLED && out_item.free_after == '1))
    else $error("saturation flag without a counter at its limit");

  // A counted action names a real class.
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.action == ACT_REUSED || out_item.action == ACT_CREATED ||
                  out_item.action == ACT_POOLED || out_item.action == ACT_DESTROYED)
    |-> {1'b0, out_item.class_index} < 4'(NUM_CLASSES))
    else $error("counted action on a class out of range");

endmodule

bind size_class_buffer_pool_accounting scbpa_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_scbpa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== sim/tb_size_class_buffer_pool_accounting.sv =====
// Self-checking testbench for the size-class buffer pool accounting block.
`timescale 1ns / 1ps

module tb_size_class_buffer_pool_accounting;
  import scbpa_pkg::*;

  localparam int N_CLASSES = NUM_CLASSES_DEF;
  localparam int MIN_LOG2 = MIN_SIZE_LOG2_DEF;
  localparam logic [2:0] OVR_CLASS = 3'(N_CLASSES);
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 40;

  // Every input is held at a known value from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  resp_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [BUDGET_W-1:0] cfg_wr_data = '0;

  // Own copy of the pool counters and the budget register.
  logic [15:0] pool_free [N_CLASSES];
  logic [15:0] pool_total [N_CLASSES];
  logic [4:0] pool_budget;

  // Results worked out at acceptance, oldest first.
  resp_t pool_updates_due [$];

  // Random idling on each side; cleared for the stretches that run flat out.
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned action_seen [6];
  int unsigned saturations_seen = 0;

  size_class_buffer_pool_accounting i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Cap on the number of buffers a class may own before a put destroys one.
  // Where the budget does not exceed the class size the exponent is held at
  // zero, so the cap is one.
  function automatic longint unsigned class_cap_at(input logic [4:0] b, input int unsigned c);
    int unsigned lg;
    lg = MIN_LOG2 + c;
    if (b <= lg) return 1;
    return 64'd1 << (b - lg);
  endfunction

  // Applies one request to the counter copy and returns the result it yields.
  function automatic resp_t pool_account(input req_t r);
    resp_t res;
    int unsigned c;
    res = '0;
    if (r.req_type == REQ_GET) begin
      // Smallest class whose buffer size holds the request; size zero lands in
      // the smallest class.
      c = 0;
      while (c < N_CLASSES && {32'd0, r.req_size} > (64'd1 << (MIN_LOG2 + c))) c++;
      if (c >= N_CLASSES) begin
        res.class_index = OVR_CLASS;
        res.action = ACT_OVR_CREATED;
        return res;
      end
      if (pool_free[c] != 0) begin
        pool_free[c]--;
        res.action = ACT_REUSED;
      end else begin
        res.action = ACT_CREATED;
        if (pool_total[c] == COUNT_MAX) res.count_saturated = 1'b1;
        else pool_total[c]++;
      end
    end else if (r.return_class >= N_CLASSES) begin
      res.class_index = OVR_CLASS;
      res.action = ACT_OVR_DESTROYED;
      return res;
    end else begin
      c = 32'(r.return_class);
      if (64'(pool_total[c]) > class_cap_at(pool_budget, c)) begin
        pool_total[c]--;
        res.action = ACT_DESTROYED;
      end else begin
        res.action = ACT_POOLED;
        if (pool_free[c] == COUNT_MAX) res.count_saturated = 1'b1;
        else pool_free[c]++;
      end
    end
    res.class_index = 3'(c);
    res.free_after = pool_free[c];
    res.total_after = pool_total[c];
    return res;
  endfunction

  // Offers one request, waits for the handshake and records its result.
  // Valid is left high on return so that a following request goes out in the
  // next cycle without a gap.
  task automatic send_request(input req_t r);
    while (in_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pool_updates_due.push_back(pool_account(r));
    items_sent++;
  endtask

  // Writes the budget register once the block has drained.
  task automatic write_budget(input logic [4:0] b);
    in_valid <= 1'b0;
    while (pool_updates_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_budget = b;
  endtask

  function automatic req_t make_get(input logic [31:0] size);
    req_t r;
    r.req_type = REQ_GET;
    r.req_size = size;
    r.return_class = 3'($urandom_range(7));
    return r;
  endfunction

  function automatic req_t make_put(input logic [2:0] cls);
    req_t r;
    r.req_type = REQ_PUT;
    r.req_size = $urandom;
    r.return_class = cls;
    return r;
  endfunction

  // Random request. Get sizes cluster on class boundaries and just inside each
  // class, with some oversized sizes and some fully random words so that every
  // size bit toggles. Most returned classes are real ones.
  function automatic req_t random_request(input int unsigned put_pct);
    req_t r;
    int unsigned pick;
    int unsigned c;
    logic [31:0] lo;
    logic [31:0] hi;
    c = $urandom_range(N_CLASSES - 1);
    hi = 32'd1 << (MIN_LOG2 + c);
    lo = (c == 0) ? 32'd0 : (hi >> 1) + 32'd1;
    pick = $urandom_range(99);
    if ($urandom_range(99) < put_pct) begin
      r = make_put(($urandom_range(99) < 85) ? 3'($urandom_range(N_CLASSES - 1))
                                             : 3'($urandom_range(7, N_CLASSES)));
    end else if (pick < 8) begin
      r = make_get($urandom);
    end else if (pick < 14) begin
      r = make_get((32'd1 << (MIN_LOG2 + N_CLASSES - 1)) + 32'd1 + $urandom_range(4095));
    end else if (pick < 34) begin
      r = make_get((pick < 24) ? hi : lo);
    end else begin
      r = make_get($urandom_range(hi, lo));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Output side: random back-pressure, and a field-by-field check of every
  // result against the oldest outstanding expectation.
  always @(posedge clk) begin
    resp_t want;
    if (rst) out_ready <= 1'b0;
    else out_ready <= out_idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    if (!rst && out_valid && out_ready) begin
      if (pool_updates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding, expected none, got %p",
                   $time, out_item);
      end else begin
        want = pool_updates_due.pop_front();
        results_checked++;
        if (want.action < 6) action_seen[want.action]++;
        if (want.count_saturated) saturations_seen++;
        if (out_item.class_index !== want.class_index)
          report_mismatch("class_index", 32'(want.class_index), 32'(out_item.class_index));
        if (out_item.action !== want.action)
          report_mismatch("action", 32'(want.action), 32'(out_item.action));
        if (out_item.free_after !== want.free_after)
          report_mismatch("free_after", 32'(want.free_after), 32'(out_item.free_after));
        if (out_item.total_after !== want.total_after)
          report_mismatch("total_after", 32'(want.total_after), 32'(out_item.total_after));
        if (out_item.count_saturated !== want.count_saturated)
          report_mismatch("count_saturated", 32'(want.count_saturated),
                          32'(out_item.count_saturated));
      end
    end
  end

  // Ends the run if neither channel completes a handshake for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pool_updates_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Every size-class boundary, size zero, the largest size and the first
  // oversized size. All classes still hold pooled buffers, so the in-range sizes reuse.
  task automatic test_size_mapping();
    logic [31:0] sizes [12] = '{32'd0, 32'd1, 32'd4096, 32'd4097, 32'd8192, 32'd8193,
                                32'd16384, 32'd32768, 32'd32769, 32'd65536, 32'd65537,
                                32'hFFFF_FFFF};
    foreach (sizes[k]) send_request(make_get(sizes[k]));
  endtask

  // A put to every class code, including the out-of-range codes that count
  // as oversized buffers.
  task automatic test_returns();
    for (int c = 0; c < 8; c++) send_request(make_put(3'(c)));
  endtask

  // Low budgets shrink the caps, holding the exponent at zero for some classes, and force
  // destruction; high budgets let other classes pool.
  task automatic test_budget_caps();
    write_budget(5'd16);
    send_request(make_put(3'd4));
    send_request(make_put(3'd3));
    write_budget(5'd0);
    send_request(make_put(3'd0));
    write_budget(5'd31);
    send_request(make_put(3'd2));
    write_budget(5'd24);
    send_request(make_put(3'd1));
  endtask

  // Phases of random traffic, each at its own budget and with a set get/put mix. Heavy
  // get phases drain the pools and create buffers; heavy put phases overrun
  // the caps. One phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [4:0] budgets [7] = '{5'd20, 5'd16, 5'd24, 5'd18, 5'd0, 5'd31, 5'd22};
    int unsigned put_pct [7] = '{50, 60, 40, 55, 70, 35, 50};
    for (int p = 0; p < 7; p++) begin
      write_budget(budgets[p]);
      in_idle_on = (p != 3);
      out_idle_on = (p != 3);
      repeat (130) send_request(random_request(put_pct[p]));
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    // Counters come out of reset at the initial entries, limited by each cap
    // at the reset budget.
    pool_budget = 5'(BUDGET_RESET);
    for (int c = 0; c < N_CLASSES; c++) begin
      pool_free[c] = (class_cap_at(pool_budget, c) < INITIAL_ENTRIES_DEF)
                     ? 16'(class_cap_at(pool_budget, c)) : 16'(INITIAL_ENTRIES_DEF);
      pool_total[c] = pool_free[c];
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_size_mapping();
    test_returns();
    test_budget_caps();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pool_updates_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests and checked %0d results across budgets 0 to 31.",
             items_sent, results_checked);
    $display("Reused %0d, created %0d, oversized %0d/%0d, pooled %0d, destroyed %0d, %0d held.",
             action_seen[ACT_REUSED], action_seen[ACT_CREATED],
             action_seen[ACT_OVR_CREATED], action_seen[ACT_OVR_DESTROYED],
             action_seen[ACT_POOLED], action_seen[ACT_DESTROYED], saturations_seen);
    if (mismatches == 0 && pool_updates_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== size_class_buffer_pool_accounting.f =====
sv/scbpa_pkg.sv
sv/scbpa_front.sv
sv/scbpa_queue.sv
sv/scbpa_back.sv
sv/size_class_buffer_pool_accounting.sv
sv/scbpa_checker.sv
sim/tb_size_class_buffer_pool_accounting.sv
